>>> sv/sal_pkg.sv
// Package with the types, constants and helpers shared by the lookup cache.
package sal_pkg;

	// SETS must be a power of two: the set index is taken from the low hash bits.
	localparam int SETS = 32;
	localparam int WAYS = 4;
	localparam int ENTRIES = SETS * WAYS;

	localparam int KEY_W = 64;
	localparam int HANDLE_W = 16;
	localparam int STAMP_W = 64;
	localparam int HASH_W = 64;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W = $clog2(WAYS + 1);
	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] handle_out;
		logic                filled;
		logic                evicted;
		logic [HANDLE_W-1:0] evicted_handle;
		logic                status;
	} res_t;

	typedef struct packed {
		logic key_eq;
		logic stamp_lt;
	} cmp_t;

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [SET_W-1:0] set_idx,
			input logic [WAY_W-1:0] way_idx);
		return ADDR_W'(set_idx) * ADDR_W'(WAYS) + ADDR_W'(way_idx);
	endfunction

endpackage

>>> sv/sal_if.sv
// Request and response channel interfaces of the lookup cache.
interface sal_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic [sal_pkg::HASH_W-1:0]    key_hash;
	logic [sal_pkg::KEY_W-1:0]     key_id;
	logic [sal_pkg::HANDLE_W-1:0]  entry_handle;
	logic [sal_pkg::STAMP_W-1:0]   now_time;
	logic                          backing_hit;
	logic [sal_pkg::HANDLE_W-1:0]  backing_handle;

	modport source (output valid, operation, key_hash, key_id, entry_handle, now_time,
		backing_hit, backing_handle, input ready);
	modport sink (input valid, operation, key_hash, key_id, entry_handle, now_time,
		backing_hit, backing_handle, output ready);
endinterface

interface sal_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [sal_pkg::HANDLE_W-1:0]  handle_out;
	logic                          filled;
	logic                          evicted;
	logic [sal_pkg::HANDLE_W-1:0]  evicted_handle;
	logic                          status;

	modport source (output valid, hit, handle_out, filled, evicted, evicted_handle, status,
		input ready);
	modport sink (input valid, hit, handle_out, filled, evicted, evicted_handle, status,
		output ready);
endinterface

>>> sv/sal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/sal_cmp.sv
// Shared compare unit: key match and stamp ordering for the way being scanned.
module sal_cmp (
	input  logic [sal_pkg::KEY_W-1:0]   key_a,
	input  logic [sal_pkg::KEY_W-1:0]   key_b,
	input  logic [sal_pkg::STAMP_W-1:0] stamp_a,
	input  logic [sal_pkg::STAMP_W-1:0] stamp_b,
	output sal_pkg::cmp_t               result
);

	always_comb begin
		result.key_eq = (key_a == key_b);
		result.stamp_lt = (stamp_a < stamp_b);
	end

endmodule

>>> sv/set_assoc_lookup_cache_lru_top.sv
// Top level of the set-associative handle cache with timestamp LRU replacement.
//
// Requests arrive on req (valid/ready); each transaction carries an operation
// (lookup, insert, remove, clear), the key hash and id, handles and the time.
// Every request produces exactly one response transaction on rsp.
// The set is key_hash modulo SETS, which is its low bits. A request scans the
// WAYS ways of its set one per cycle through a shared compare unit fed by the
// entry RAM, then writes at most one entry. The sequencer takes no new
// request until the response of the current one is in the output register.
// A clear skips the scan and the decision step and goes straight to the
// done state, where its all-zero response is loaded.
// req.ready is high only while the sequencer is idle. The response sits in
// an output register, so the next request is accepted while an earlier
// response is still stalled; the sequencer then waits before delivering,
// and req.ready stays low until the earlier response has left.
// Reset clears all valid bits at once; the entry RAM needs no clearing pass.
module set_assoc_lookup_cache_lru_top (
	input  logic      clk,
	input  logic      arst_n,
	sal_req_if.sink   req,
	sal_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	state_t state_q;

	sal_pkg::op_t                      op_q;
	logic [sal_pkg::SET_W-1:0]         set_q;
	logic [sal_pkg::KEY_W-1:0]         key_q;
	logic [sal_pkg::HANDLE_W-1:0]      ehandle_q;
	logic [sal_pkg::STAMP_W-1:0]       now_q;
	logic                              bhit_q;
	logic [sal_pkg::HANDLE_W-1:0]      bhandle_q;

	logic [sal_pkg::ENTRIES-1:0]       valid_q;

	logic [sal_pkg::WCNT_W-1:0]        rd_way_q;
	logic                              chk_vld_s1;
	logic [sal_pkg::WAY_W-1:0]         chk_way_s1;

	logic                              found_q;
	logic [sal_pkg::WAY_W-1:0]         found_way_q;
	logic [sal_pkg::HANDLE_W-1:0]      found_handle_q;
	logic                              empty_q;
	logic [sal_pkg::WAY_W-1:0]         empty_way_q;
	logic [sal_pkg::WAY_W-1:0]         oldest_way_q;
	logic [sal_pkg::STAMP_W-1:0]       oldest_stamp_q;
	logic [sal_pkg::HANDLE_W-1:0]      oldest_handle_q;

	sal_pkg::res_t                     res_q;
	sal_pkg::res_t                     out_q;
	logic                              rsp_valid_q;

	logic                              ram_re;
	logic [sal_pkg::ADDR_W-1:0]        ram_raddr;
	logic                              ram_we;
	logic [sal_pkg::ADDR_W-1:0]        ram_waddr;
	sal_pkg::entry_t                   ram_wdata;
	sal_pkg::entry_t                   ram_rdata;
	logic [sal_pkg::ADDR_W-1:0]        chk_addr;
	logic                              chk_entry_vld;
	sal_pkg::cmp_t                     cmp;

	logic                              dec_we;
	logic                              dec_set_valid;
	logic                              dec_clr_valid;
	logic [sal_pkg::WAY_W-1:0]         dec_way;
	logic [sal_pkg::HANDLE_W-1:0]      dec_handle;
	sal_pkg::res_t                     dec_res;
	logic                              req_fire;
	logic                              rsp_load;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	// The output register takes a new response once it is empty or being drained.
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	sal_ram #(
		.WIDTH(sal_pkg::ENTRY_W),
		.DEPTH(sal_pkg::ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sal_cmp u_cmp (
		.key_a  (ram_rdata.key),
		.key_b  (key_q),
		.stamp_a(ram_rdata.stamp),
		.stamp_b(oldest_stamp_q),
		.result (cmp)
	);

	always_comb begin
		ram_re = (state_q == ST_SCAN) && (rd_way_q < sal_pkg::WCNT_W'(sal_pkg::WAYS));
		ram_raddr = sal_pkg::entry_addr(set_q, rd_way_q[sal_pkg::WAY_W-1:0]);
		chk_addr = sal_pkg::entry_addr(set_q, chk_way_s1);
		chk_entry_vld = valid_q[chk_addr];
	end

	// Outcome of a finished scan: the response and at most one entry update.
	always_comb begin
		dec_we = 1'b0;
		dec_set_valid = 1'b0;
		dec_clr_valid = 1'b0;
		dec_way = found_way_q;
		dec_handle = found_handle_q;
		dec_res = '0;
		unique case (op_q)
			sal_pkg::OP_LOOKUP: begin
				if (found_q) begin
					dec_we = 1'b1;
					dec_res.hit = 1'b1;
					dec_res.handle_out = found_handle_q;
				end else if (bhit_q) begin
					dec_res.handle_out = bhandle_q;
					if (empty_q) begin
						dec_we = 1'b1;
						dec_set_valid = 1'b1;
						dec_way = empty_way_q;
						dec_handle = bhandle_q;
						dec_res.filled = 1'b1;
					end
				end else begin
					dec_res.status = 1'b1;
				end
			end
			sal_pkg::OP_INSERT: begin
				dec_we = 1'b1;
				dec_set_valid = 1'b1;
				dec_handle = ehandle_q;
				if (empty_q) begin
					dec_way = empty_way_q;
				end else begin
					dec_way = oldest_way_q;
					dec_res.evicted = 1'b1;
					dec_res.evicted_handle = oldest_handle_q;
				end
			end
			sal_pkg::OP_REMOVE: begin
				if (found_q) begin
					dec_clr_valid = 1'b1;
				end else begin
					dec_res.status = 1'b1;
				end
			end
			sal_pkg::OP_CLEAR: begin
				dec_res = '0;
			end
			default: begin
				dec_res = '0;
			end
		endcase
		ram_we = (state_q == ST_DECIDE) && dec_we;
		ram_waddr = sal_pkg::entry_addr(set_q, dec_way);
		ram_wdata = '{key: key_q, handle: dec_handle, stamp: now_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			rsp_valid_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
			rd_way_q <= '0;
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			chk_vld_s1 <= ram_re;
			chk_way_s1 <= rd_way_q[sal_pkg::WAY_W-1:0];
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						op_q <= sal_pkg::op_t'(req.operation);
						key_q <= req.key_id;
						ehandle_q <= req.entry_handle;
						now_q <= req.now_time;
						bhit_q <= req.backing_hit;
						bhandle_q <= req.backing_handle;
						rd_way_q <= '0;
						found_q <= 1'b0;
						empty_q <= 1'b0;
						if (sal_pkg::op_t'(req.operation) == sal_pkg::OP_CLEAR) begin
							valid_q <= '0;
							res_q <= '0;
							state_q <= ST_DONE;
						end else begin
							set_q <= req.key_hash[sal_pkg::SET_W-1:0];
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						rd_way_q <= rd_way_q + 1'b1;
					end
					if (chk_vld_s1) begin
						if (chk_entry_vld && cmp.key_eq && !found_q) begin
							found_q <= 1'b1;
							found_way_q <= chk_way_s1;
							found_handle_q <= ram_rdata.handle;
						end
						if (!chk_entry_vld && !empty_q) begin
							empty_q <= 1'b1;
							empty_way_q <= chk_way_s1;
						end
						// Way 0 seeds the oldest candidate; later ways replace it only
						// when strictly older, so the lowest index wins ties.
						if (chk_way_s1 == '0 || cmp.stamp_lt) begin
							oldest_way_q <= chk_way_s1;
							oldest_stamp_q <= ram_rdata.stamp;
							oldest_handle_q <= ram_rdata.handle;
						end
						if (chk_way_s1 == sal_pkg::WAY_W'(sal_pkg::WAYS - 1)) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					res_q <= dec_res;
					if (dec_set_valid) begin
						valid_q[ram_waddr] <= 1'b1;
					end
					if (dec_clr_valid) begin
						valid_q[ram_waddr] <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						out_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.hit = out_q.hit;
	assign rsp.handle_out = out_q.handle_out;
	assign rsp.filled = out_q.filled;
	assign rsp.evicted = out_q.evicted;
	assign rsp.evicted_handle = out_q.evicted_handle;
	assign rsp.status = out_q.status;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request accepted while the sequencer was busy");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.operation == sal_pkg::OP_CLEAR) |=> (valid_q == '0))
		else $error("clear left valid entries behind");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("entry RAM written while the scan still reads it");

	a_evict_only_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && dec_res.evicted) |-> (op_q == sal_pkg::OP_INSERT && !empty_q))
		else $error("eviction outside an insert into a full set");

endmodule

>>> tb/sv/tb_set_assoc_lookup_cache_lru_top.sv
// Testbench for the set-associative handle cache: random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_set_assoc_lookup_cache_lru_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 500;
	localparam int HOT_SETS = 4;
	localparam int HOT_KEYS = 24;

	typedef struct {
		sal_pkg::op_t                 operation;
		logic [sal_pkg::HASH_W-1:0]   key_hash;
		logic [sal_pkg::KEY_W-1:0]    key_id;
		logic [sal_pkg::HANDLE_W-1:0] entry_handle;
		logic [sal_pkg::STAMP_W-1:0]  now_time;
		logic                         backing_hit;
		logic [sal_pkg::HANDLE_W-1:0] backing_handle;
	} cache_req_t;

	logic clk;
	logic arst_n;

	sal_req_if req ();
	sal_rsp_if rsp ();

	set_assoc_lookup_cache_lru_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Predicted contents of the cache, set-major like the entry RAM.
	bit                           cache_valid  [sal_pkg::ENTRIES];
	logic [sal_pkg::KEY_W-1:0]    cache_key    [sal_pkg::ENTRIES];
	logic [sal_pkg::HANDLE_W-1:0] cache_handle [sal_pkg::ENTRIES];
	logic [sal_pkg::STAMP_W-1:0]  cache_stamp  [sal_pkg::ENTRIES];

	cache_req_t    req_backlog [$];
	sal_pkg::res_t due_rsp [$];
	cache_req_t    in_flight;

	int n_total = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int err_count = 0;
	int cycle_count = 0;

	logic [sal_pkg::KEY_W-1:0] hot_key [HOT_KEYS];
	int                        hot_set [HOT_SETS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random hash whose residue modulo SETS is the requested set.
	function automatic logic [sal_pkg::HASH_W-1:0] hash_for_set(int set_idx);
		logic [sal_pkg::HASH_W-1:0] h;
		h = rand64();
		return h - (h % sal_pkg::SETS) + sal_pkg::HASH_W'(set_idx);
	endfunction

	// 0: sender idles lightly, receiver heavily; 1: the reverse; 2: no idling.
	function automatic int traffic_phase();
		int p;
		p = (n_total == 0) ? 0 : (n_accepted * 3) / n_total;
		return (p > 2) ? 2 : p;
	endfunction

	// Applies one request to the predicted cache and returns the response it must produce.
	function automatic sal_pkg::res_t apply_request(cache_req_t it);
		sal_pkg::res_t r;
		int            base;
		int            empty;
		int            found;
		int            target;
		int            oldest;
		int            i;
		r = '0;
		base = int'(it.key_hash % sal_pkg::SETS) * sal_pkg::WAYS;
		empty = -1;
		found = -1;
		target = -1;
		oldest = 0;
		case (it.operation)
			sal_pkg::OP_LOOKUP: begin
				for (int w = 0; w < sal_pkg::WAYS && found < 0; w++) begin
					i = base + w;
					if (cache_valid[i]) begin
						if (cache_key[i] == it.key_id)
							found = w;
					end else if (empty < 0) begin
						empty = w;
					end
				end
				if (found >= 0) begin
					cache_stamp[base + found] = it.now_time;
					r.hit = 1'b1;
					r.handle_out = cache_handle[base + found];
				end else if (it.backing_hit) begin
					r.handle_out = it.backing_handle;
					// A full set is left alone; the backing handle is only passed through.
					if (empty >= 0) begin
						i = base + empty;
						cache_valid[i] = 1'b1;
						cache_key[i] = it.key_id;
						cache_handle[i] = it.backing_handle;
						cache_stamp[i] = it.now_time;
						r.filled = 1'b1;
					end
				end else begin
					r.status = 1'b1;
				end
			end
			sal_pkg::OP_INSERT: begin
				for (int w = 0; w < sal_pkg::WAYS && target < 0; w++) begin
					i = base + w;
					if (!cache_valid[i])
						target = w;
					else if (cache_stamp[i] < cache_stamp[base + oldest])
						oldest = w;
				end
				if (target < 0) begin
					target = oldest;
					r.evicted = 1'b1;
					r.evicted_handle = cache_handle[base + target];
				end
				i = base + target;
				cache_valid[i] = 1'b1;
				cache_key[i] = it.key_id;
				cache_handle[i] = it.entry_handle;
				cache_stamp[i] = it.now_time;
			end
			sal_pkg::OP_REMOVE: begin
				r.status = 1'b1;
				for (int w = 0; w < sal_pkg::WAYS && found < 0; w++) begin
					i = base + w;
					if (cache_valid[i] && cache_key[i] == it.key_id)
						found = w;
				end
				if (found >= 0) begin
					cache_valid[base + found] = 1'b0;
					r.status = 1'b0;
				end
			end
			default: begin
				for (int k = 0; k < sal_pkg::ENTRIES; k++)
					cache_valid[k] = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic queue_request(sal_pkg::op_t op, logic [sal_pkg::HASH_W-1:0] h,
			logic [sal_pkg::KEY_W-1:0] k, logic [sal_pkg::HANDLE_W-1:0] eh,
			logic [sal_pkg::STAMP_W-1:0] now, logic bh,
			logic [sal_pkg::HANDLE_W-1:0] bhandle);
		cache_req_t it;
		it.operation = op;
		it.key_hash = h;
		it.key_id = k;
		it.entry_handle = eh;
		it.now_time = now;
		it.backing_hit = bh;
		it.backing_handle = bhandle;
		req_backlog.insert(req_backlog.size(), it);
	endtask

	task automatic build_directed();
		logic [sal_pkg::KEY_W-1:0]  dk [5];
		logic [sal_pkg::HASH_W-1:0] h3;
		for (int j = 0; j < 5; j++)
			dk[j] = rand64();
		h3 = hash_for_set(3);
		// Empty set: total miss, then a fill from the backing store, then a hit.
		queue_request(sal_pkg::OP_LOOKUP, h3, dk[0], 16'h0000, 64'd1, 1'b0, 16'hFFFF);
		queue_request(sal_pkg::OP_LOOKUP, h3, dk[0], 16'hFFFF, 64'd0, 1'b1, 16'hFFFF);
		queue_request(sal_pkg::OP_LOOKUP, hash_for_set(3), dk[0], 16'h0000, 64'd10, 1'b0,
			16'h0000);
		queue_request(sal_pkg::OP_INSERT, h3, dk[1], 16'h0000, 64'd5, 1'b1, 16'h7777);
		queue_request(sal_pkg::OP_INSERT, h3, dk[2], 16'h1234, 64'd5, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_INSERT, h3, dk[3], 16'hABCD, 64'd5, 1'b0, 16'h0000);
		// Backing hit on a full set, then evictions that break stamp ties by way order.
		queue_request(sal_pkg::OP_LOOKUP, h3, dk[4], 16'h0000, 64'd6, 1'b1, 16'h5555);
		queue_request(sal_pkg::OP_INSERT, h3, dk[4], 16'h4444, 64'd20, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_INSERT, h3, dk[2], 16'h2222, 64'd21, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_REMOVE, h3, dk[3], 16'hFFFF, 64'd22, 1'b1, 16'hFFFF);
		queue_request(sal_pkg::OP_REMOVE, h3, dk[3], 16'h0000, 64'd22, 1'b0, 16'h0000);
		// A second copy of a cached key; lookups and removes see the lower way first.
		queue_request(sal_pkg::OP_INSERT, h3, dk[2], 16'h3333, 64'd23, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_LOOKUP, h3, dk[2], 16'h0000, 64'd24, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_REMOVE, h3, dk[2], 16'h0000, 64'd24, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_LOOKUP, h3, dk[2], 16'h0000, 64'd25, 1'b0, 16'h0000);
		// Field extremes.
		queue_request(sal_pkg::OP_INSERT, '1, '1, 16'hFFFF, '1, 1'b1, 16'hFFFF);
		queue_request(sal_pkg::OP_LOOKUP, '1, '1, 16'h0000, '1, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_LOOKUP, '0, '0, 16'hFFFF, '0, 1'b1, 16'h0000);
		queue_request(sal_pkg::OP_INSERT, '0, '0, 16'h0000, '1, 1'b0, 16'hFFFF);
		queue_request(sal_pkg::OP_REMOVE, '0, '1, 16'h0000, '0, 1'b0, 16'h0000);
		queue_request(sal_pkg::OP_CLEAR, rand64(), rand64(), 16'hFFFF, rand64(), 1'b1,
			16'hFFFF);
		queue_request(sal_pkg::OP_LOOKUP, h3, dk[0], 16'h0000, 64'd30, 1'b0, 16'h0000);
	endtask

	// Mostly traffic on a few crowded sets with a small pool of keys, so that hits,
	// fills, evictions and removes all happen often; a few fully random requests.
	task automatic build_random();
		logic [sal_pkg::STAMP_W-1:0] tick;
		logic [sal_pkg::STAMP_W-1:0] now;
		int                          pick;
		int                          roll;
		sal_pkg::op_t                op;
		logic [sal_pkg::HASH_W-1:0]  h;
		logic [sal_pkg::KEY_W-1:0]   k;
		tick = 64'd100;
		for (int j = 0; j < HOT_SETS; j++)
			hot_set[j] = int'($urandom_range(sal_pkg::SETS - 1));
		for (int j = 0; j < HOT_KEYS; j++)
			hot_key[j] = rand64();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tick = tick + 64'($urandom_range(3));
			now = ($urandom_range(99) < 5) ? rand64() : tick;
			pick = int'($urandom_range(HOT_KEYS - 1));
			h = hash_for_set(hot_set[pick % HOT_SETS]);
			k = hot_key[pick];
			roll = int'($urandom_range(99));
			if (roll < 1) begin
				op = sal_pkg::OP_CLEAR;
			end else if (roll < 40) begin
				op = sal_pkg::OP_LOOKUP;
			end else if (roll < 74) begin
				op = sal_pkg::OP_INSERT;
			end else if (roll < 94) begin
				op = sal_pkg::OP_REMOVE;
			end else begin
				op = sal_pkg::op_t'(2'($urandom_range(3)));
				h = rand64();
				k = rand64();
			end
			queue_request(op, h, k, 16'($urandom), now, 1'($urandom), 16'($urandom));
		end
	endtask

	// Driver: presents the backlog and predicts each transaction as it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= sal_pkg::OP_LOOKUP;
			req.key_hash <= '0;
			req.key_id <= '0;
			req.entry_handle <= '0;
			req.now_time <= '0;
			req.backing_hit <= 1'b0;
			req.backing_handle <= '0;
		end else begin
			if (req.valid && req.ready) begin
				due_rsp.insert(due_rsp.size(), apply_request(in_flight));
				n_accepted++;
			end
			if (!req.valid || req.ready) begin
				if (req_backlog.size() != 0 &&
						$urandom_range(99) >= (traffic_phase() == 0 ? 22 :
						traffic_phase() == 1 ? 80 : 0)) begin
					in_flight = req_backlog.pop_front();
					req.operation <= in_flight.operation;
					req.key_hash <= in_flight.key_hash;
					req.key_id <= in_flight.key_id;
					req.entry_handle <= in_flight.entry_handle;
					req.now_time <= in_flight.now_time;
					req.backing_hit <= in_flight.backing_hit;
					req.backing_handle <= in_flight.backing_handle;
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string msg);
		if (err_count < 60)
			$display("[%0t] response %0d: %s", $realtime, n_checked, msg);
		err_count++;
	endtask

	// Monitor: checks every response transaction against the oldest prediction.
	always @(posedge clk) begin
		sal_pkg::res_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_rsp.size() == 0) begin
					report_mismatch("no request outstanding");
				end else begin
					want = due_rsp.pop_front();
					if (rsp.hit !== want.hit)
						report_mismatch($sformatf("hit is 0x%0h, predicted 0x%0h",
							rsp.hit, want.hit));
					if (rsp.handle_out !== want.handle_out)
						report_mismatch($sformatf("handle_out is 0x%0h, predicted 0x%0h",
							rsp.handle_out, want.handle_out));
					if (rsp.filled !== want.filled)
						report_mismatch($sformatf("filled is 0x%0h, predicted 0x%0h",
							rsp.filled, want.filled));
					if (rsp.evicted !== want.evicted)
						report_mismatch($sformatf("evicted is 0x%0h, predicted 0x%0h",
							rsp.evicted, want.evicted));
					if (rsp.evicted_handle !== want.evicted_handle)
						report_mismatch($sformatf("evicted_handle is 0x%0h, predicted 0x%0h",
							rsp.evicted_handle, want.evicted_handle));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status is 0x%0h, predicted 0x%0h",
							rsp.status, want.status));
				end
				n_checked++;
			end
			rsp.ready <= ($urandom_range(99) >= (traffic_phase() == 0 ? 80 :
				traffic_phase() == 1 ? 22 : 0));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] run timed out", $realtime);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		build_directed();
		build_random();
		n_total = req_backlog.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (n_accepted < n_total)
			@(posedge clk);
		while (due_rsp.size() != 0)
			@(posedge clk);
		// Leave room for any stray response to show up.
		repeat (sal_pkg::WAYS + 16) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
